[rtl/core/b32d_pkg.sv]
// Shared types and constants for the base32 stream decoder.
`default_nettype none
package b32d_pkg;

	localparam int unsigned CFG_ADDR_W     = 3;
	localparam int unsigned CFG_DATA_W     = 32;
	localparam int unsigned QUEUE_DEPTH    = 2;
	localparam logic [7:0]  PAD_CHAR_RESET = 8'd61;
	localparam logic [0:0]  REG_PAD_CHAR   = 1'b0;

	localparam logic [7:0]  CHAR_A   = 8'h41;
	localparam logic [7:0]  CHAR_Z   = 8'h5a;
	localparam logic [7:0]  CHAR_2   = 8'h32;
	localparam logic [7:0]  CHAR_7   = 8'h37;
	localparam logic [4:0]  DIGIT_26 = 5'd26;

	typedef enum logic [1:0] {
		STATUS_BYTE = 2'd0,
		STATUS_END  = 2'd1,
		STATUS_ERR  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_SYMBOL  = 2'd0,
		KIND_PAD     = 2'd1,
		KIND_INVALID = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [4:0] value;
		logic       last;
	} item_t;

endpackage
`default_nettype wire

[rtl/core/b32d_front.sv]
// Front stage: accepts characters and classifies them as symbol, pad or invalid.
`default_nettype none
module b32d_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    pad_char,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    char_code,
	input  wire logic          end_of_string,
	output logic               push_valid,
	input  wire logic          push_ready,
	output b32d_pkg::item_t    push_item
);
	import b32d_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;

	always_comb begin
		item_d.last  = end_of_string;
		item_d.value = '0;
		if (char_code == pad_char) begin
			item_d.kind = KIND_PAD;
		end else if (char_code >= CHAR_A && char_code <= CHAR_Z) begin
			item_d.kind  = KIND_SYMBOL;
			item_d.value = 5'(char_code - CHAR_A);
		end else if (char_code >= CHAR_2 && char_code <= CHAR_7) begin
			item_d.kind  = KIND_SYMBOL;
			item_d.value = 5'(char_code - CHAR_2) + DIGIT_26;
		end else begin
			item_d.kind = KIND_INVALID;
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/b32d_queue.sv]
// Short queue of classified items between the front and back stages.
`default_nettype none
module b32d_queue #(
	parameter int unsigned DEPTH = b32d_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire b32d_pkg::item_t wr_item,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output b32d_pkg::item_t    rd_item
);
	import b32d_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = count_q != FULL_CNT;
	assign rd_valid = count_q != '0;
	assign rd_item  = entry_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

[rtl/core/b32d_back.sv]
// Back stage: bit accumulator, byte extraction and the registered result item.
`default_nettype none
module b32d_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	output logic               pop_ready,
	input  wire b32d_pkg::item_t pop_item,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         data_byte,
	output logic [1:0]         status,
	output logic               string_done
);
	import b32d_pkg::*;

	logic [6:0]  acc_q;
	logic [2:0]  held_q;
	logic        skipping_q;
	logic        error_q;
	logic        out_valid_q;
	logic [7:0]  data_q;
	status_t     status_q;
	logic        done_q;

	logic        do_pop;
	logic        give;
	logic [7:0]  data_d;
	status_t     status_d;
	logic [6:0]  acc_d;
	logic [2:0]  held_d;
	logic        skipping_d;
	logic        error_d;
	logic [11:0] acc_wide;
	logic [3:0]  n_wide;
	logic [2:0]  rem;
	logic [11:0] shifted;
	logic [11:0] kept;

	assign pop_ready = !out_valid_q || out_ready;
	assign do_pop    = pop_valid && pop_ready;

	always_comb begin
		acc_wide   = {acc_q, pop_item.value};
		n_wide     = {1'b0, held_q} + 4'd5;
		rem        = 3'(n_wide - 4'd8);
		shifted    = acc_wide >> rem;
		kept       = acc_wide & ((12'd1 << rem) - 12'd1);
		give       = 1'b0;
		data_d     = '0;
		status_d   = STATUS_END;
		acc_d      = acc_q;
		held_d     = held_q;
		skipping_d = skipping_q;
		error_d    = error_q;
		if (!skipping_q) begin
			case (pop_item.kind)
				KIND_PAD: begin
					skipping_d = 1'b1;
				end
				KIND_SYMBOL: begin
					if (n_wide >= 4'd8) begin
						give     = 1'b1;
						status_d = STATUS_BYTE;
						data_d   = shifted[7:0];
						acc_d    = kept[6:0];
						held_d   = rem;
					end else begin
						acc_d  = acc_wide[6:0];
						held_d = n_wide[2:0];
					end
				end
				default: begin
					skipping_d = 1'b1;
					error_d    = 1'b1;
					give       = 1'b1;
					status_d   = STATUS_ERR;
				end
			endcase
		end
		if (pop_item.last) begin
			if (!give) begin
				status_d = error_q ? STATUS_ERR : STATUS_END;
			end
			give       = 1'b1;
			acc_d      = '0;
			held_d     = '0;
			skipping_d = 1'b0;
			error_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			held_q      <= '0;
			skipping_q  <= 1'b0;
			error_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				acc_q      <= acc_d;
				held_q     <= held_d;
				skipping_q <= skipping_d;
				error_q    <= error_d;
			end
			if (do_pop && give) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && give) begin
			data_q   <= data_d;
			status_q <= status_d;
			done_q   <= pop_item.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_byte   = data_q;
	assign status      = status_q;
	assign string_done = done_q;

endmodule
`default_nettype wire

[rtl/core/base32_stream_decoder.sv]
// Top level of the base32 stream decoder with its configuration register.
// A character passes through the front register and the queue before it reaches the output register.
// Throughput: one character per cycle while the receiver keeps m_tready high.
// The front register, queue and output register decouple the two sides.
// Reset is asynchronous and active low; it clears all string state and sets
// pad_char to 61.
`default_nettype none
module base32_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = b32d_pkg::QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// Fields from bit 0: char_code[7:0].
	input  wire logic [7:0]                       s_tdata,
	input  wire logic                             s_tlast,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// Fields from bit 0: data_byte[7:0], status[9:8], zero fill [15:10].
	output logic [15:0]                           m_tdata,
	output logic                                  m_tlast,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [b32d_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [b32d_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [b32d_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                  pready
);
	import b32d_pkg::*;

	logic [7:0] pad_q;
	logic       push_valid;
	logic       push_ready;
	item_t      push_item;
	logic       pop_valid;
	logic       pop_ready;
	item_t      pop_item;
	logic [7:0] data_byte;
	logic [1:0] status;
	logic       reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = paddr[CFG_ADDR_W-1:2] == REG_PAD_CHAR;
	assign prdata  = reg_hit ? CFG_DATA_W'(pad_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= PAD_CHAR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			pad_q <= pwdata[7:0];
		end
	end

	b32d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.pad_char      (pad_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.char_code     (s_tdata),
		.end_of_string (s_tlast),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	b32d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_item  (push_item),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_item  (pop_item)
	);

	b32d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.data_byte   (data_byte),
		.status      (status),
		.string_done (m_tlast)
	);

	assign m_tdata = {6'b0, status, data_byte};

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the base32 stream decoder.
`timescale 1ns / 100ps
module tb_top;
	import b32d_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int SETTLE      = 8;
	localparam int LONG_HOLD   = 150;
	localparam int PHASE_CHARS = 200;
	localparam logic [CFG_ADDR_W-1:0] PAD_CHAR_ADDR = CFG_ADDR_W'(4 * REG_PAD_CHAR);

	typedef struct packed {
		logic [7:0] data_byte;
		status_t    status;
		logic       string_done;
	} decoded_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic                  m_tlast;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// Decoder state as the predictor tracks it.
	logic [7:0]  pad_model = PAD_CHAR_RESET;
	logic [15:0] acc_bits = '0;
	logic [3:0]  held_count = '0;
	bit          skip_rest = 1'b0;
	bit          string_bad = 1'b0;

	decoded_t decoded_q[$];
	int       err_count = 0;
	int       cycle_count = 0;
	int       chars_sent = 0;
	int       strings_sent = 0;
	int       pad_settings = 0;
	int       bytes_seen = 0;
	int       ends_seen = 0;
	int       errors_seen = 0;
	int       rx_stall_left = 0;
	bit       long_hold_req = 1'b0;
	bit       tx_steady = 1'b0;
	bit       rx_steady = 1'b0;

	base32_stream_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_symbol();
		int r;
		r = $urandom_range(0, 31);
		if (r < 26)
			return CHAR_A + 8'(r);
		return CHAR_2 + 8'(r - 26);
	endfunction

	function automatic bit decode_char(input logic [7:0] ch, input bit last,
			output decoded_t res);
		int  v;
		int  wide;
		int  n;
		bit  give;
		res.data_byte   = '0;
		res.status      = STATUS_END;
		res.string_done = last;
		give = 1'b0;
		if (!skip_rest) begin
			if (ch == pad_model) begin
				skip_rest = 1'b1;
			end else begin
				if (ch >= CHAR_A && ch <= CHAR_Z)
					v = int'(ch) - int'(CHAR_A);
				else if (ch >= CHAR_2 && ch <= CHAR_7)
					v = int'(ch) - int'(CHAR_2) + int'(DIGIT_26);
				else
					v = -1;
				if (v < 0) begin
					skip_rest  = 1'b1;
					string_bad = 1'b1;
					res.status = STATUS_ERR;
					give = 1'b1;
				end else begin
					wide = (int'(acc_bits) << 5) | v;
					n = int'(held_count) + 5;
					if (n >= 8) begin
						n -= 8;
						res.data_byte = 8'(wide >> n);
						wide &= (1 << n) - 1;
						res.status = STATUS_BYTE;
						give = 1'b1;
					end
					acc_bits   = 16'(wide);
					held_count = 4'(n);
				end
			end
		end
		if (last) begin
			if (!give)
				res.status = string_bad ? STATUS_ERR : STATUS_END;
			give = 1'b1;
			acc_bits   = '0;
			held_count = '0;
			skip_rest  = 1'b0;
			string_bad = 1'b0;
		end
		return give;
	endfunction

	// The receiver stalls at random; a long hold is counted here on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			rx_stall_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (rx_steady || $urandom_range(0, 3) != 0) begin
			m_tready <= 1'b1;
		end else begin
			rx_stall_left = pick_gap() - 1;
			m_tready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && m_tvalid && m_tready) begin
			case (status_t'(m_tdata[9:8]))
				STATUS_BYTE: bytes_seen++;
				STATUS_END: ends_seen++;
				default: errors_seen++;
			endcase
			if (decoded_q.size() == 0) begin
				$error("unexpected result: tdata %h tlast %b", m_tdata, m_tlast);
				err_count++;
			end else begin
				want = decoded_q.pop_front();
				if (m_tdata[7:0] !== want.data_byte) begin
					$error("data_byte: expected %h, actual %h", want.data_byte, m_tdata[7:0]);
					err_count++;
				end
				if (m_tdata[9:8] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tdata[9:8]);
					err_count++;
				end
				if (m_tlast !== want.string_done) begin
					$error("string_done: expected %b, actual %b", want.string_done, m_tlast);
					err_count++;
				end
				if (m_tdata[15:10] !== 6'd0) begin
					$error("fill: expected 0, actual %h", m_tdata[15:10]);
					err_count++;
				end
			end
		end
	end

	task automatic send_char(input logic [7:0] ch, input bit last);
		decoded_t res;
		int       gap;
		gap = (tx_steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (decode_char(ch, last, res))
			decoded_q.insert(decoded_q.size(), res);
		chars_sent++;
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_char(text[i], i == text.len() - 1);
		strings_sent++;
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	task automatic wait_drained();
		hold_until_drained();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write_pad(input logic [7:0] pad);
		logic [CFG_DATA_W-1:0] word;
		word = $urandom();
		word[7:0] = pad;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PAD_CHAR_ADDR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pad_model = pad;
		pad_settings++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== pad_model) begin
			$error("pad_char: expected %h, actual %h", pad_model, prdata[7:0]);
			err_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_string();
		int         len;
		int         kind;
		int         bad_at;
		int         pad_at;
		logic [7:0] ch;
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
		kind = $urandom_range(0, 9);
		bad_at = (kind == 8) ? $urandom_range(0, len - 1) : -1;
		pad_at = (kind == 6 || kind == 7) ? $urandom_range(0, len - 1) : len;
		for (int i = 0; i < len; i++) begin
			if (kind == 9 || i == bad_at)
				ch = 8'($urandom_range(0, 255));
			else if (i >= pad_at && $urandom_range(0, 3) != 0)
				ch = pad_model;
			else
				ch = pick_symbol();
			if ($urandom_range(0, 49) == 0)
				hold_until_drained();
			send_char(ch, i == len - 1);
		end
		strings_sent++;
	endtask

	task automatic run_strings(input int count);
		int start;
		start = chars_sent;
		while (chars_sent - start < count)
			send_random_string();
	endtask

	task automatic test_directed();
		send_text("MZXW6===");
		send_text("Z7A2");
		send_text("MY1Q");
		send_text("a");
		send_text("ME");
		send_text("A");
		send_char(8'h00, 1'b1);
		send_char(8'hff, 1'b1);
		wait_drained();
		// A pad character that is also a letter must still stop decoding.
		cfg_write_pad(CHAR_A);
		send_text("BAC");
		wait_drained();
	endtask

	task automatic test_pad_settings();
		logic [7:0] pads[6];
		pads = '{PAD_CHAR_RESET, 8'h00, 8'hff, CHAR_Z, CHAR_2, 8'($urandom_range(0, 255))};
		foreach (pads[k]) begin
			cfg_write_pad(pads[k]);
			run_strings(PHASE_CHARS);
			wait_drained();
		end
	endtask

	task automatic test_long_backpressure();
		long_hold_req = 1'b1;
		tx_steady = 1'b1;
		run_strings(64);
		tx_steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_full_rate();
		cfg_write_pad(PAD_CHAR_RESET);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		run_strings(PHASE_CHARS);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		run_strings(PHASE_CHARS / 2);
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pad_settings();
		test_long_backpressure();
		test_full_rate();
		wait_drained();
		$display("Sent %0d characters in %0d strings under %0d pad settings.",
			chars_sent, strings_sent, pad_settings);
		$display("Received %0d bytes, %0d plain string ends and %0d error results.",
			bytes_seen, ends_seen, errors_seen);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
